// ===== hdl/cac_pkg.sv =====
// Shared constants, tables and reset values of the color angle classifier.
package cac_pkg;

   localparam int SAMPLE_BITS_DEF     = 10;
   localparam int NUM_CLASSES_DEF     = 4;
   localparam int ANGLE_FRAC_BITS_DEF = 4;

   localparam int REG_BITS      = 13;
   localparam int CLASS_BITS    = 2;
   localparam int CORDIC_STEPS  = 23;
   localparam int PRESCALE_BITS = 24;
   localparam int DEG_Q16_BITS  = 16;
   localparam int XY_MARGIN     = 4;
   localparam int Z_W           = 26;
   localparam int SENSORS       = 2;

   localparam logic signed [Z_W-1:0] DEG180_Q16 = Z_W'(11796480);

   function automatic logic signed [Z_W-1:0] atan_q16(input int step);
      case (step)
         0:       return Z_W'(2949120);
         1:       return Z_W'(1740967);
         2:       return Z_W'(919879);
         3:       return Z_W'(466945);
         4:       return Z_W'(234379);
         5:       return Z_W'(117304);
         6:       return Z_W'(58666);
         7:       return Z_W'(29335);
         8:       return Z_W'(14668);
         9:       return Z_W'(7334);
         10:      return Z_W'(3667);
         11:      return Z_W'(1833);
         12:      return Z_W'(917);
         13:      return Z_W'(458);
         14:      return Z_W'(229);
         15:      return Z_W'(115);
         16:      return Z_W'(57);
         17:      return Z_W'(29);
         18:      return Z_W'(14);
         19:      return Z_W'(7);
         20:      return Z_W'(4);
         21:      return Z_W'(2);
         22:      return Z_W'(1);
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [REG_BITS-1:0] reset_angle(input int sensor, input int cls);
      if (sensor == 0) begin
         case (cls)
            0:       return REG_BITS'(456);
            1:       return REG_BITS'(400);
            2:       return REG_BITS'(688);
            3:       return REG_BITS'(320);
            default: return '0;
         endcase
      end else begin
         case (cls)
            0:       return REG_BITS'(579);
            1:       return REG_BITS'(544);
            2:       return REG_BITS'(640);
            3:       return REG_BITS'(496);
            default: return '0;
         endcase
      end
   endfunction

endpackage

// ===== hdl/cac_if.sv =====
// Handshake channel interfaces: sample request, class response, register write.
interface cac_req_if #(
   parameter int SAMPLE_BITS = cac_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] ambient_a;
   logic [SAMPLE_BITS-1:0] red_lit_a;
   logic [SAMPLE_BITS-1:0] blue_lit_a;
   logic [SAMPLE_BITS-1:0] ambient_b;
   logic [SAMPLE_BITS-1:0] red_lit_b;
   logic [SAMPLE_BITS-1:0] blue_lit_b;

   modport source (output valid, ambient_a, red_lit_a, blue_lit_a,
                   ambient_b, red_lit_b, blue_lit_b, input ready);
   modport sink   (input valid, ambient_a, red_lit_a, blue_lit_a,
                   ambient_b, red_lit_b, blue_lit_b, output ready);
endinterface

interface cac_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cac_pkg::CLASS_BITS-1:0]  class_a;
   logic [cac_pkg::CLASS_BITS-1:0]  class_b;

   modport source (output valid, class_a, class_b, input ready);
   modport sink   (input valid, class_a, class_b, output ready);
endinterface

interface cac_csr_if #(
   parameter int IDX_W = $clog2(2 * cac_pkg::NUM_CLASSES_DEF) + 1
);
   logic                          valid;
   logic                          ready;
   logic [IDX_W-1:0]              index;
   logic [cac_pkg::REG_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cac_cell.sv =====
// One CORDIC vectoring iteration cell with its stage registers.
module cac_cell #(
   parameter int SHIFT = 0,
   parameter int XY_W  = cac_pkg::SAMPLE_BITS_DEF + cac_pkg::PRESCALE_BITS + cac_pkg::XY_MARGIN
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [XY_W-1:0]           x_src,
   input  logic signed [XY_W-1:0]           y_src,
   input  logic signed [cac_pkg::Z_W-1:0]   z_src,
   input  logic                             zero_src,
   output logic signed [XY_W-1:0]           x_out,
   output logic signed [XY_W-1:0]           y_out,
   output logic signed [cac_pkg::Z_W-1:0]   z_out,
   output logic                             zero_out
);

   localparam logic signed [cac_pkg::Z_W-1:0] ATAN = cac_pkg::atan_q16(SHIFT);

   logic signed [XY_W-1:0]         xs, ys;
   logic signed [XY_W-1:0]         x_in, y_in, x_ff, y_ff;
   logic signed [cac_pkg::Z_W-1:0] z_in, z_ff;
   logic                           zero_ff;

   always_comb begin
      xs = x_src >>> SHIFT;
      ys = y_src >>> SHIFT;
      if (!y_src[XY_W-1]) begin
         x_in = x_src + ys;
         y_in = y_src - xs;
         z_in = z_src + ATAN;
      end else begin
         x_in = x_src - ys;
         y_in = y_src + xs;
         z_in = z_src - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_src;
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign zero_out = zero_ff;

endmodule

// ===== hdl/cac_round.sv =====
// Rounds the Q16 degree angle to output resolution and clamps it to +-180 degrees.
module cac_round #(
   parameter int ANGLE_FRAC_BITS = cac_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic signed [cac_pkg::Z_W-1:0]       z,
   input  logic                                 zero,
   output logic signed [ANGLE_FRAC_BITS+8:0]    angle
);

   localparam int SH    = cac_pkg::DEG_Q16_BITS - ANGLE_FRAC_BITS;
   localparam int ANG_W = ANGLE_FRAC_BITS + 9;
   localparam int SUM_W = cac_pkg::Z_W + 1;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (SH - 1));
   localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(180 << ANGLE_FRAC_BITS);

   logic signed [SUM_W-1:0] sum, shifted;

   always_comb begin
      sum     = SUM_W'(z) + HALF;
      shifted = sum >>> SH;
      if (zero) begin
         angle = '0;
      end else if (shifted > LIM) begin
         angle = ANG_W'(LIM);
      end else if (shifted < -LIM) begin
         angle = ANG_W'(-LIM);
      end else begin
         angle = ANG_W'(shifted);
      end
   end

endmodule

// ===== hdl/cac_pick.sv =====
// Picks the calibrated class nearest to the measured angle, lowest class on a tie.
module cac_pick #(
   parameter int NUM_CLASSES     = cac_pkg::NUM_CLASSES_DEF,
   parameter int ANGLE_FRAC_BITS = cac_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic signed [ANGLE_FRAC_BITS+8:0]       angle,
   input  logic signed [cac_pkg::REG_BITS-1:0]     angles [NUM_CLASSES],
   output logic [cac_pkg::CLASS_BITS-1:0]          class_o
);

   localparam int ANG_W = ANGLE_FRAC_BITS + 9;
   localparam int D_W   = ((ANG_W > cac_pkg::REG_BITS) ? ANG_W : cac_pkg::REG_BITS) + 1;
   localparam int IDX_W = $clog2(NUM_CLASSES);

   logic signed [D_W-1:0] d  [NUM_CLASSES];
   logic [D_W-1:0]        ad [NUM_CLASSES];
   logic [D_W-1:0]        best_d;
   logic [IDX_W-1:0]      best;

   always_comb begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
         d[k]  = D_W'(angle) - D_W'(angles[k]);
         ad[k] = d[k][D_W-1] ? D_W'(-d[k]) : D_W'(d[k]);
      end
   end

   always_comb begin
      best_d = ad[0];
      best   = '0;
      for (int k = 1; k < NUM_CLASSES; k++) begin
         if (ad[k] < best_d) begin
            best_d = ad[k];
            best   = IDX_W'(k);
         end
      end
      class_o = cac_pkg::CLASS_BITS'(best);
   end

endmodule

// ===== hdl/color_angle_classifier.sv =====
// Top level: sample prep, CORDIC cell row per sensor, rounding and class pick.
// Pipeline stages from request accept to response valid: 1 prep, 23 CORDIC cells,
// 1 round/clamp, 1 class pick/output register; one item per cycle when not stalled.
// Each pipeline stage advances when its successor is empty or advancing, so bubbles fill.
// Reset clears all stage valid bits and loads the calibration angles with their defaults.
// Register writes complete in the cycle they are presented.
module color_angle_classifier #(
   parameter int SAMPLE_BITS     = cac_pkg::SAMPLE_BITS_DEF,
   parameter int NUM_CLASSES     = cac_pkg::NUM_CLASSES_DEF,
   parameter int ANGLE_FRAC_BITS = cac_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cac_req_if.sink    req_if,
   cac_rsp_if.source  rsp_if,
   cac_csr_if.sink    csr_if
);

   localparam int NCELL     = cac_pkg::CORDIC_STEPS;
   localparam int NST       = NCELL + 3;
   localparam int XY_W      = SAMPLE_BITS + cac_pkg::PRESCALE_BITS + cac_pkg::XY_MARGIN;
   localparam int Z_W       = cac_pkg::Z_W;
   localparam int ANG_W     = ANGLE_FRAC_BITS + 9;
   localparam int CSR_IDX_W = $clog2(2 * NUM_CLASSES) + 1;
   localparam int NS        = cac_pkg::SENSORS;
   localparam int LIM       = 180 << ANGLE_FRAC_BITS;

   logic [NST:0]   en;
   logic [NST-1:0] valid_ff, valid_in, valid_shift;

   logic [SAMPLE_BITS-1:0]      amb [NS], rl [NS], bl [NS];
   logic signed [SAMPLE_BITS:0] red_d [NS], blue_d [NS], red_p [NS], blue_p [NS];

   logic signed [XY_W-1:0] prep_x_ff [NS], prep_x_in [NS];
   logic signed [XY_W-1:0] prep_y_ff [NS], prep_y_in [NS];
   logic signed [Z_W-1:0]  prep_z_ff [NS], prep_z_in [NS];
   logic                   prep_zero_ff [NS], prep_zero_in [NS];

   logic signed [XY_W-1:0] x_st    [NS][NCELL+1];
   logic signed [XY_W-1:0] y_st    [NS][NCELL+1];
   logic signed [Z_W-1:0]  z_st    [NS][NCELL+1];
   logic                   zero_st [NS][NCELL+1];

   logic signed [ANG_W-1:0]                ang_in [NS], ang_ff [NS];
   logic [cac_pkg::CLASS_BITS-1:0]         class_in [NS], class_ff [NS];
   logic signed [cac_pkg::REG_BITS-1:0]    angle_ff [NS][NUM_CLASSES];
   logic signed [cac_pkg::REG_BITS-1:0]    angle_in [NS][NUM_CLASSES];

   // stage handshake chain
   assign en[NST] = rsp_if.ready;
   for (genvar j = 0; j < NST; j++) begin : g_en
      assign en[j] = !valid_ff[j] || en[j+1];
   end

   assign req_if.ready = en[0];
   assign valid_shift  = {valid_ff[NST-2:0], req_if.valid};

   always_comb begin
      for (int j = 0; j < NST; j++) begin
         valid_in[j] = en[j] ? valid_shift[j] : valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // sample prep: ambient removal, left half-plane fold, prescale
   assign amb[0] = req_if.ambient_a;
   assign rl[0]  = req_if.red_lit_a;
   assign bl[0]  = req_if.blue_lit_a;
   assign amb[1] = req_if.ambient_b;
   assign rl[1]  = req_if.red_lit_b;
   assign bl[1]  = req_if.blue_lit_b;

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         red_d[s]  = $signed({1'b0, rl[s]}) - $signed({1'b0, amb[s]});
         blue_d[s] = $signed({1'b0, bl[s]}) - $signed({1'b0, amb[s]});
         red_p[s]  = red_d[s][SAMPLE_BITS] ? -red_d[s]  : red_d[s];
         blue_p[s] = red_d[s][SAMPLE_BITS] ? -blue_d[s] : blue_d[s];
         prep_x_in[s] = XY_W'(red_p[s]) <<< cac_pkg::PRESCALE_BITS;
         prep_y_in[s] = XY_W'(blue_p[s]) <<< cac_pkg::PRESCALE_BITS;
         if (red_d[s][SAMPLE_BITS]) begin
            prep_z_in[s] = blue_d[s][SAMPLE_BITS] ? -cac_pkg::DEG180_Q16 : cac_pkg::DEG180_Q16;
         end else begin
            prep_z_in[s] = '0;
         end
         prep_zero_in[s] = (red_d[s] == '0) && (blue_d[s] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prep_x_ff    <= prep_x_in;
         prep_y_ff    <= prep_y_in;
         prep_z_ff    <= prep_z_in;
         prep_zero_ff <= prep_zero_in;
      end
   end

   // CORDIC cell rows, round and pick per sensor
   for (genvar s = 0; s < NS; s++) begin : g_sensor
      assign x_st[s][0]    = prep_x_ff[s];
      assign y_st[s][0]    = prep_y_ff[s];
      assign z_st[s][0]    = prep_z_ff[s];
      assign zero_st[s][0] = prep_zero_ff[s];

      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         cac_cell #(
            .SHIFT (k),
            .XY_W  (XY_W)
         ) u_cell (
            .clock    (clock),
            .en       (en[k+1]),
            .x_src    (x_st[s][k]),
            .y_src    (y_st[s][k]),
            .z_src    (z_st[s][k]),
            .zero_src (zero_st[s][k]),
            .x_out    (x_st[s][k+1]),
            .y_out    (y_st[s][k+1]),
            .z_out    (z_st[s][k+1]),
            .zero_out (zero_st[s][k+1])
         );
      end

      cac_round #(
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
      ) u_round (
         .z     (z_st[s][NCELL]),
         .zero  (zero_st[s][NCELL]),
         .angle (ang_in[s])
      );

      cac_pick #(
         .NUM_CLASSES     (NUM_CLASSES),
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
      ) u_pick (
         .angle   (ang_ff[s]),
         .angles  (angle_ff[s]),
         .class_o (class_in[s])
      );
   end

   always_ff @(posedge clock) begin
      if (en[NCELL+1]) begin
         ang_ff <= ang_in;
      end
      if (en[NCELL+2]) begin
         class_ff <= class_in;
      end
   end

   assign rsp_if.valid   = valid_ff[NST-1];
   assign rsp_if.class_a = class_ff[0];
   assign rsp_if.class_b = class_ff[1];

   // calibration angle registers
   assign csr_if.ready = 1'b1;

   always_comb begin
      angle_in = angle_ff;
      for (int s = 0; s < NS; s++) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            if (csr_if.valid && csr_if.ready &&
                csr_if.index == CSR_IDX_W'(s * NUM_CLASSES + k)) begin
               angle_in[s][k] = csr_if.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
               angle_ff[s][k] <= cac_pkg::reset_angle(s, k);
            end
         end
      end else begin
         angle_ff <= angle_in;
      end
   end

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&valid_ff))
      else $error("request stalled while a pipeline stage is empty");

   a_folded_x: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (!prep_x_ff[0][XY_W-1] && !prep_x_ff[1][XY_W-1]))
      else $error("prepared x is negative");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NCELL+1] |-> (ang_ff[0] <= LIM && ang_ff[0] >= -LIM &&
                             ang_ff[1] <= LIM && ang_ff[1] >= -LIM))
      else $error("rounded angle outside clamp range");

endmodule
